@@ src/multichannel_square_tone_generator_top_assert.svh @@
// Assertion macros for the square tone generator.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef MULTICHANNEL_SQUARE_TONE_GENERATOR_TOP_ASSERT_SVH
`define MULTICHANNEL_SQUARE_TONE_GENERATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCSTG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCSTG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/mcstg_pkg.sv @@
// Package for the square tone generator: operation codes, note period table,
// and the noise generator helpers. Depends on nothing else.
package mcstg_pkg;

	localparam int PeriodW = 17;
	localparam int DutyW   = 7;
	localparam int LfsrW   = 16;
	localparam int LevelsW = 4;
	localparam int ProdW   = PeriodW + DutyW;

	localparam logic [DutyW-1:0] DutyReset = 7'd50;
	localparam logic [DutyW-1:0] DutyMax   = 7'd100;
	localparam logic [LfsrW-1:0] LfsrSeed  = 16'hACE1;

	localparam int Modulus    = 100;
	localparam int RecipShift = 22;
	localparam int RecipMod   = (1 << RecipShift) / Modulus;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_NOTE_ON  = 3'd1,
		OP_NOTE_OFF = 3'd2,
		OP_SET_DUTY = 3'd3,
		OP_NOISE_ON = 3'd4
	} op_t;

	typedef logic [PeriodW-1:0] period_t;

	localparam period_t NotePeriod [128] = '{
		17'd122312, 17'd115447, 17'd108967, 17'd102851, 17'd97079, 17'd91630,
		17'd86487, 17'd81633, 17'd77051, 17'd72727, 17'd68645, 17'd64792,
		17'd61156, 17'd57723, 17'd54483, 17'd51425, 17'd48539, 17'd45815,
		17'd43243, 17'd40816, 17'd38525, 17'd36363, 17'd34322, 17'd32396,
		17'd30578, 17'd28861, 17'd27241, 17'd25712, 17'd24269, 17'd22907,
		17'd21621, 17'd20408, 17'd19262, 17'd18181, 17'd17161, 17'd16198,
		17'd15289, 17'd14430, 17'd13620, 17'd12856, 17'd12134, 17'd11453,
		17'd10810, 17'd10204, 17'd9631, 17'd9090, 17'd8580, 17'd8099,
		17'd7644, 17'd7215, 17'd6810, 17'd6428, 17'd6067, 17'd5726,
		17'd5405, 17'd5102, 17'd4815, 17'd4545, 17'd4290, 17'd4049,
		17'd3822, 17'd3607, 17'd3405, 17'd3214, 17'd3033, 17'd2863,
		17'd2702, 17'd2551, 17'd2407, 17'd2272, 17'd2145, 17'd2024,
		17'd1911, 17'd1803, 17'd1702, 17'd1607, 17'd1516, 17'd1431,
		17'd1351, 17'd1275, 17'd1203, 17'd1136, 17'd1072, 17'd1012,
		17'd955, 17'd901, 17'd851, 17'd803, 17'd758, 17'd715,
		17'd675, 17'd637, 17'd601, 17'd568, 17'd536, 17'd506,
		17'd477, 17'd450, 17'd425, 17'd401, 17'd379, 17'd357,
		17'd337, 17'd318, 17'd300, 17'd284, 17'd268, 17'd253,
		17'd238, 17'd225, 17'd212, 17'd200, 17'd189, 17'd178,
		17'd168, 17'd159, 17'd150, 17'd142, 17'd134, 17'd126,
		17'd119, 17'd112, 17'd106, 17'd100, 17'd94, 17'd89,
		17'd84, 17'd79
	};

	function automatic logic [LfsrW-1:0] lfsr_step(input logic [LfsrW-1:0] s);
		logic fb;
		fb = s[0] ^ s[2] ^ s[3] ^ s[5];
		return {fb, s[LfsrW-1:1]};
	endfunction

	// The reciprocal is rounded down, so the quotient is at most one short.
	function automatic logic [DutyW-1:0] mod100(input logic [LfsrW-1:0] x);
		logic [31:0] prod;
		logic [9:0]  q;
		logic [16:0] r;
		prod = 32'(x) * 32'(RecipMod);
		q    = prod[31:RecipShift];
		r    = 17'(x) - 17'(q) * 17'(Modulus);
		if (r >= 17'(Modulus)) begin
			r = r - 17'(Modulus);
		end
		return r[DutyW-1:0];
	endfunction

endpackage

@@ src/multichannel_square_tone_generator_top.sv @@
// Square tone generator with up to CHANNELS channels and a word-wide level output.
// Depends on mcstg_pkg and the assertion macro header.
// An accepted item's levels word is registered in the output or skid register.
// Throughput: one word per clock; a skid register keeps input open while a
// finished word waits, and the input stalls only when both are full.
// Reset clears all channel state to silent, duty 50, and seeds the noise LFSR.
`include "multichannel_square_tone_generator_top_assert.svh"

module multichannel_square_tone_generator_top #(
	parameter int CHANNELS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [1:0] channel,
	input  logic [6:0] note,
	input  logic [6:0] duty_percent,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] levels
);

	localparam int CntW = $clog2(CHANNELS + 1);
	localparam int LvlN = (CHANNELS < mcstg_pkg::LevelsW) ? CHANNELS : mcstg_pkg::LevelsW;

	logic [2:0]                       count_q;
	mcstg_pkg::period_t               period_q [CHANNELS];
	mcstg_pkg::period_t               phase_q  [CHANNELS];
	logic [mcstg_pkg::DutyW-1:0]      duty_q   [CHANNELS];
	logic [CHANNELS-1:0]              noise_q;
	logic [CHANNELS-1:0]              level_q;
	logic [mcstg_pkg::LfsrW-1:0]      lfsr_q;

	mcstg_pkg::period_t               period_nx [CHANNELS];
	mcstg_pkg::period_t               phase_nx  [CHANNELS];
	logic [mcstg_pkg::DutyW-1:0]      duty_nx   [CHANNELS];
	logic [CHANNELS-1:0]              noise_nx;
	logic [CHANNELS-1:0]              level_nx;
	logic [mcstg_pkg::LfsrW-1:0]      lfsr_nx;

	logic [mcstg_pkg::LfsrW-1:0]      lfsr_steps [CHANNELS+1];
	logic [mcstg_pkg::DutyW-1:0]      draw_val   [1:CHANNELS];
	logic [3:0]                       levels_new;

	logic       accept;
	logic       out_take;
	logic       out_valid_q;
	logic       skid_valid_q;
	logic [3:0] levels_q;
	logic [3:0] skid_levels_q;

	assign accept   = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;
	assign in_stall = skid_valid_q;
	assign out_valid = out_valid_q;
	assign levels    = levels_q;

	// Noise draws for one, two, ... steps ahead of the current LFSR state.
	always_comb begin
		lfsr_steps[0] = lfsr_q;
		for (int k = 1; k <= CHANNELS; k++) begin
			lfsr_steps[k] = mcstg_pkg::lfsr_step(lfsr_steps[k-1]);
			draw_val[k]   = mcstg_pkg::mod100(lfsr_steps[k]);
		end
	end

	always_comb begin
		logic [CntW-1:0]              draws;
		logic [mcstg_pkg::PeriodW-1:0] ph1;
		logic [mcstg_pkg::ProdW-1:0]   thr_x100;
		logic [mcstg_pkg::ProdW-1:0]   ph_x100;
		logic [mcstg_pkg::DutyW-1:0]   sat_duty;
		draws    = '0;
		ph1      = '0;
		thr_x100 = '0;
		ph_x100  = '0;
		sat_duty = (duty_percent > mcstg_pkg::DutyMax) ? mcstg_pkg::DutyMax : duty_percent;
		lfsr_nx  = lfsr_q;
		for (int c = 0; c < CHANNELS; c++) begin
			period_nx[c] = period_q[c];
			phase_nx[c]  = phase_q[c];
			duty_nx[c]   = duty_q[c];
			noise_nx[c]  = noise_q[c];
			level_nx[c]  = level_q[c];
		end
		case (mcstg_pkg::op_t'(operation))
			mcstg_pkg::OP_TICK: begin
				for (int c = 0; c < CHANNELS; c++) begin
					ph1      = phase_q[c] + 1'b1;
					thr_x100 = {{mcstg_pkg::DutyW{1'b0}}, period_q[c]}
						* {{mcstg_pkg::PeriodW{1'b0}}, duty_q[c]};
					ph_x100  = mcstg_pkg::ProdW'(ph1) * mcstg_pkg::ProdW'(mcstg_pkg::Modulus);
					if ((32'(count_q) > c) && (period_q[c] != '0)) begin
						phase_nx[c] = ph1;
						level_nx[c] = (ph_x100 <= thr_x100);
						if (ph1 >= period_q[c]) begin
							phase_nx[c] = '0;
							if (noise_q[c]) begin
								duty_nx[c] = draw_val[draws + CntW'(1)];
								draws      = draws + CntW'(1);
							end
						end
					end
				end
				lfsr_nx = lfsr_steps[draws];
			end
			mcstg_pkg::OP_NOTE_ON: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (32'(channel) == c) begin
						period_nx[c] = mcstg_pkg::NotePeriod[note];
					end
				end
			end
			mcstg_pkg::OP_NOTE_OFF: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (32'(channel) == c) begin
						period_nx[c] = '0;
						noise_nx[c]  = 1'b0;
					end
				end
			end
			mcstg_pkg::OP_SET_DUTY: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (32'(channel) == c) begin
						duty_nx[c]  = sat_duty;
						noise_nx[c] = 1'b0;
					end
				end
			end
			mcstg_pkg::OP_NOISE_ON: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (32'(channel) == c) begin
						period_nx[c] = mcstg_pkg::NotePeriod[note];
						duty_nx[c]   = draw_val[1];
						noise_nx[c]  = 1'b1;
						lfsr_nx      = lfsr_steps[1];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		levels_new = '0;
		for (int c = 0; c < LvlN; c++) begin
			levels_new[c] = level_nx[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd1;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				period_q[c] <= '0;
				phase_q[c]  <= '0;
				duty_q[c]   <= mcstg_pkg::DutyReset;
			end
			noise_q <= '0;
			level_q <= '0;
			lfsr_q  <= mcstg_pkg::LfsrSeed;
		end else if (accept) begin
			for (int c = 0; c < CHANNELS; c++) begin
				period_q[c] <= period_nx[c];
				phase_q[c]  <= phase_nx[c];
				duty_q[c]   <= duty_nx[c];
			end
			noise_q <= noise_nx;
			level_q <= level_nx;
			lfsr_q  <= lfsr_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= skid_valid_q || accept;
			end
			if (skid_valid_q && out_take) begin
				skid_valid_q <= 1'b0;
			end else if (accept && out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			levels_q <= skid_valid_q ? skid_levels_q : levels_new;
		end
		if (accept) begin
			skid_levels_q <= levels_new;
		end
	end

	`MCSTG_ASSERT_SAME(a_skid_needs_out, skid_valid_q, out_valid_q,
		"Skid register holds a word while the output register is empty.")
	`MCSTG_ASSERT_NEXT(a_cmd_keeps_levels,
		accept && (operation != mcstg_pkg::OP_TICK), level_q == $past(level_q),
		"A command word changed the channel levels.")
	`MCSTG_ASSERT_NEXT(a_silent_holds, accept && (period_q[0] == '0),
		level_q[0] == $past(level_q[0]), "A silent channel changed its level.")
	`MCSTG_ASSERT_SAME(a_duty_range, 1'b1, duty_q[0] <= mcstg_pkg::DutyMax,
		"Channel duty exceeds one hundred percent.")

endmodule

@@ bench/mcstg_levels_checker.sv @@
// Checker for the square tone generator: watches all four channels, predicts the levels word
// for every accepted input word and compares it with the word that the block returns.
// Depends on mcstg_pkg for the operation codes.
`timescale 1ns / 100ps

module mcstg_levels_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [2:0] operation,
	input  logic [1:0] channel,
	input  logic [6:0] note,
	input  logic [6:0] duty_percent,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [3:0] levels,
	output int         mismatches,
	output int         awaited
);

	localparam int NumCh = 4;
	localparam int ReportMax = 10;

	localparam logic [16:0] NoteTable [128] = '{
		17'd122312, 17'd115447, 17'd108967, 17'd102851, 17'd97079, 17'd91630, 17'd86487,
		17'd81633, 17'd77051, 17'd72727, 17'd68645, 17'd64792, 17'd61156, 17'd57723,
		17'd54483, 17'd51425, 17'd48539, 17'd45815, 17'd43243, 17'd40816, 17'd38525,
		17'd36363, 17'd34322, 17'd32396, 17'd30578, 17'd28861, 17'd27241, 17'd25712,
		17'd24269, 17'd22907, 17'd21621, 17'd20408, 17'd19262, 17'd18181, 17'd17161,
		17'd16198, 17'd15289, 17'd14430, 17'd13620, 17'd12856, 17'd12134, 17'd11453,
		17'd10810, 17'd10204, 17'd9631, 17'd9090, 17'd8580, 17'd8099, 17'd7644,
		17'd7215, 17'd6810, 17'd6428, 17'd6067, 17'd5726, 17'd5405, 17'd5102,
		17'd4815, 17'd4545, 17'd4290, 17'd4049, 17'd3822, 17'd3607, 17'd3405,
		17'd3214, 17'd3033, 17'd2863, 17'd2702, 17'd2551, 17'd2407, 17'd2272,
		17'd2145, 17'd2024, 17'd1911, 17'd1803, 17'd1702, 17'd1607, 17'd1516,
		17'd1431, 17'd1351, 17'd1275, 17'd1203, 17'd1136, 17'd1072, 17'd1012,
		17'd955, 17'd901, 17'd851, 17'd803, 17'd758, 17'd715, 17'd675,
		17'd637, 17'd601, 17'd568, 17'd536, 17'd506, 17'd477, 17'd450,
		17'd425, 17'd401, 17'd379, 17'd357, 17'd337, 17'd318, 17'd300,
		17'd284, 17'd268, 17'd253, 17'd238, 17'd225, 17'd212, 17'd200,
		17'd189, 17'd178, 17'd168, 17'd159, 17'd150, 17'd142, 17'd134,
		17'd126, 17'd119, 17'd112, 17'd106, 17'd100, 17'd94, 17'd89,
		17'd84, 17'd79
	};

	logic [16:0] period_q [NumCh];
	logic [16:0] phase_q [NumCh];
	logic [6:0]  duty_q [NumCh];
	logic        noise_q [NumCh];
	logic        level_q [NumCh];
	logic [15:0] lfsr_q;
	logic [2:0]  active_q;
	logic [3:0]  levels_due [$];

	function automatic logic [6:0] draw_noise_duty();
		logic fb;
		fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
		lfsr_q = {fb, lfsr_q[15:1]};
		return 7'(lfsr_q % 16'd100);
	endfunction

	task automatic advance_tone_state(input logic [2:0] op, input logic [1:0] ch,
			input logic [6:0] nt, input logic [6:0] pct);
		int unsigned limit;
		int unsigned thr;
		logic [3:0] word;
		case (op)
			mcstg_pkg::OP_TICK: begin
				limit = (active_q > NumCh) ? NumCh : active_q;
				for (int c = 0; c < limit; c++) begin
					if (period_q[c] != '0) begin
						phase_q[c] = phase_q[c] + 17'd1;
						thr = (32'(period_q[c]) * 32'(duty_q[c])) / 32'd100;
						level_q[c] = (32'(phase_q[c]) <= thr);
						if (phase_q[c] >= period_q[c]) begin
							phase_q[c] = '0;
							if (noise_q[c]) begin
								duty_q[c] = draw_noise_duty();
							end
						end
					end
				end
			end
			mcstg_pkg::OP_NOTE_ON: begin
				period_q[ch] = NoteTable[nt];
			end
			mcstg_pkg::OP_NOTE_OFF: begin
				period_q[ch] = '0;
				noise_q[ch] = 1'b0;
			end
			mcstg_pkg::OP_SET_DUTY: begin
				duty_q[ch] = (pct > 7'd100) ? 7'd100 : pct;
				noise_q[ch] = 1'b0;
			end
			mcstg_pkg::OP_NOISE_ON: begin
				period_q[ch] = NoteTable[nt];
				duty_q[ch] = draw_noise_duty();
				noise_q[ch] = 1'b1;
			end
			default: begin
			end
		endcase
		for (int c = 0; c < NumCh; c++) begin
			word[c] = level_q[c];
		end
		levels_due.push_back(word);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NumCh; c++) begin
				period_q[c] = '0;
				phase_q[c] = '0;
				duty_q[c] = 7'd50;
				noise_q[c] = 1'b0;
				level_q[c] = 1'b0;
			end
			lfsr_q = 16'hACE1;
			active_q = 3'd1;
			levels_due.delete();
			mismatches = 0;
			awaited = 0;
		end else begin
			if (cfg_wr_en) begin
				active_q = cfg_wr_data;
			end
			if (out_valid && !out_stall) begin
				if (levels_due.size() == 0) begin
					if (mismatches < ReportMax) begin
						$display("unexpected levels word %b at %0t", levels, $realtime);
					end
					mismatches++;
				end else if (levels !== levels_due[0]) begin
					if (mismatches < ReportMax) begin
						$display("levels mismatch at %0t: expected %b, actual %b",
							$realtime, levels_due[0], levels);
					end
					mismatches++;
					void'(levels_due.pop_front());
				end else begin
					void'(levels_due.pop_front());
				end
			end
			if (in_valid && !in_stall) begin
				advance_tone_state(operation, channel, note, duty_percent);
			end
			awaited = levels_due.size();
		end
	end

endmodule

@@ bench/tb_multichannel_square_tone_generator_top.sv @@
// Testbench top for the square tone generator: drives directed and random command and
// tick words with random gaps and output stalls, and gives the verdict.
// Depends on mcstg_pkg, the block and mcstg_levels_checker.
`timescale 1ns / 100ps

module tb_multichannel_square_tone_generator_top;

	localparam logic [2:0] OpFirstUnused = 3'd5;
	localparam logic [2:0] OpLastUnused  = 3'd7;
	localparam int CycleLimit = 400000;
	localparam int WordsPerPhase = 183;
	localparam logic [2:0] CountPlan [9] = '{3'd4, 3'd2, 3'd0, 3'd7, 3'd3, 3'd5, 3'd1,
		3'd6, 3'd4};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [2:0] cfg_wr_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] operation = '0;
	logic [1:0] channel = '0;
	logic [6:0] note = '0;
	logic [6:0] duty_percent = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [3:0] levels;

	int  mismatches;
	int  awaited;
	int  cycles = 0;
	int  hold_left = 0;
	int  stall_draw;
	bit  tx_calm = 1'b0;
	bit  rx_calm = 1'b0;

	multichannel_square_tone_generator_top #(
		.CHANNELS(4)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.channel(channel),
		.note(note),
		.duty_percent(duty_percent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.levels(levels)
	);

	mcstg_levels_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.channel(channel),
		.note(note),
		.duty_percent(duty_percent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.levels(levels),
		.mismatches(mismatches),
		.awaited(awaited)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Unless in its calm mode, the receiver holds off for a random number of cycles after each word it takes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= (hold_left != 1);
			end else if (out_valid && !out_stall) begin
				if ($urandom_range(0, 39) == 0) begin
					rx_calm <= !rx_calm;
				end
				if (rx_calm) begin
					hold_left <= 0;
					out_stall <= 1'b0;
				end else begin
					stall_draw = $urandom_range(0, 11);
					hold_left <= stall_draw;
					out_stall <= (stall_draw != 0);
				end
			end
		end
	end

	task automatic send_word(input logic [2:0] op, input logic [1:0] ch,
			input logic [6:0] nt, input logic [6:0] pct);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		channel <= ch;
		note <= nt;
		duty_percent <= pct;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drive_random_word();
		int pick;
		logic [2:0] op;
		logic [6:0] nt;
		if ($urandom_range(0, 39) == 0) begin
			tx_calm = !tx_calm;
		end
		pick = $urandom_range(0, 99);
		nt = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
			: 7'($urandom_range(100, 127));
		if (pick < 70) begin
			op = mcstg_pkg::OP_TICK;
		end else if (pick < 78) begin
			op = mcstg_pkg::OP_NOTE_ON;
		end else if (pick < 82) begin
			op = mcstg_pkg::OP_NOTE_OFF;
		end else if (pick < 90) begin
			op = mcstg_pkg::OP_SET_DUTY;
		end else if (pick < 96) begin
			op = mcstg_pkg::OP_NOISE_ON;
		end else begin
			op = 3'($urandom_range(OpFirstUnused, OpLastUnused));
		end
		send_word(op, 2'($urandom_range(0, 3)), nt, 7'($urandom_range(0, 127)));
	endtask

	task automatic set_channel_count(input logic [2:0] count);
		in_valid <= 1'b0;
		do @(negedge clk); while (awaited != 0);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= count;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(mcstg_pkg::OP_TICK, 2'd0, 7'd0, 7'd0);
		send_word(mcstg_pkg::OP_NOTE_ON, 2'd0, 7'd127, 7'd0);
		send_word(mcstg_pkg::OP_SET_DUTY, 2'd0, 7'd0, 7'd127);
		repeat (3) send_word(mcstg_pkg::OP_TICK, 2'd3, 7'd127, 7'd127);
		send_word(mcstg_pkg::OP_SET_DUTY, 2'd0, 7'd0, 7'd0);
		repeat (2) send_word(mcstg_pkg::OP_TICK, 2'd0, 7'd0, 7'd0);
		send_word(mcstg_pkg::OP_SET_DUTY, 2'd0, 7'd0, 7'd100);
		send_word(mcstg_pkg::OP_NOTE_ON, 2'd1, 7'd0, 7'd0);
		send_word(mcstg_pkg::OP_NOISE_ON, 2'd2, 7'd120, 7'd0);
		send_word(mcstg_pkg::OP_NOISE_ON, 2'd3, 7'd127, 7'd127);
		send_word(mcstg_pkg::OP_TICK, 2'd0, 7'd0, 7'd0);
		send_word(mcstg_pkg::OP_NOTE_OFF, 2'd0, 7'd127, 7'd127);
		send_word(mcstg_pkg::OP_TICK, 2'd0, 7'd0, 7'd0);
		send_word(OpFirstUnused, 2'd3, 7'd127, 7'd127);
		send_word(OpLastUnused, 2'd0, 7'd0, 7'd0);
		send_word(mcstg_pkg::OP_SET_DUTY, 2'd3, 7'd0, 7'd101);
		send_word(mcstg_pkg::OP_NOTE_ON, 2'd0, 7'd100, 7'd0);
		repeat (2) send_word(mcstg_pkg::OP_TICK, 2'd0, 7'd0, 7'd0);

		foreach (CountPlan[i]) begin
			set_channel_count(CountPlan[i]);
			repeat (WordsPerPhase) drive_random_word();
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (awaited != 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && awaited == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ multichannel_square_tone_generator_top.f @@
+incdir+src
src/mcstg_pkg.sv
src/multichannel_square_tone_generator_top.sv
bench/mcstg_levels_checker.sv
bench/tb_multichannel_square_tone_generator_top.sv
